// ===== design/fbcp_pkg.sv =====
// ----------------------------------------------------------------------------
// fbcp_pkg
// Shared types and constants for the framebuffer circle plotter: action codes,
// error term type and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package fbcp_pkg;

  // Action codes carried in the low bits of the input transaction
  localparam logic [2:0] ACT_SET    = 3'd0;
  localparam logic [2:0] ACT_CLR    = 3'd1;
  localparam logic [2:0] ACT_CIRCLE = 3'd2;
  localparam logic [2:0] ACT_WIPE   = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // Input field widths
  localparam int ACTION_W = 3;
  localparam int POS_X_W  = 7;
  localparam int POS_Y_W  = 5;
  localparam int RADIUS_W = 6;
  localparam int INDEX_W  = 9;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 8;

  // Midpoint error term, wide enough for any radius up to 63
  typedef logic signed [9:0] err_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // capture input transaction
    logic pt_rd;     // compute point address, read its byte
    logic pt_wr;     // write modified byte back
    logic pt_next;   // advance to next symmetric point
    logic step;      // advance midpoint error term
    logic clr_wr;    // write zero at sweep address
    logic rd_issue;  // read byte for read action
    logic rd_cap;    // capture read byte
    logic fin_load;  // load result into output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [2:0] action;  // action field of the offered transaction
    logic       last_pt; // current point is the last of its group
    logic       a_lt_b;  // circle still has steps to go
    logic       clr_last; // sweep is at its last byte
  } sts_t;

endpackage

// ===== design/framebuffer_circle_plotter.sv =====
// ----------------------------------------------------------------------------
// framebuffer_circle_plotter
// Monochrome page-organised framebuffer with pixel set/clear, midpoint
// circle outline, full clear and byte read, on stream-style channels.
// ----------------------------------------------------------------------------
// One transaction is processed at a time; every transaction gives exactly one
// result. Pixel (x, y) sits in byte (y/8)*DISPLAY_WIDTH + x at bit y%8.
// A circle takes S midpoint steps (about 0.71 times the radius). Every
// plotted point is a read-modify-write of the frame store: a read state and
// then a write state, and points are not overlapped. After reset the block
// runs a clearing pass over all DISPLAY_WIDTH*DISPLAY_PAGES bytes (512 by
// default) before in_tready rises. A finished result waits in the output
// register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module framebuffer_circle_plotter #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int DISPLAY_PAGES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // action[2:0], pos_x[9:3], pos_y[14:10],
                                  // radius[20:15], byte_index[29:21], zero[31:30]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // read_data[7:0]
);

  fbcp_pkg::cmd_t cmd;
  fbcp_pkg::sts_t sts;

  // Sequencer
  fbcp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Frame store and arithmetic
  fbcp_datapath #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_PAGES (DISPLAY_PAGES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

// ===== design/fbcp_ram.sv =====
// ----------------------------------------------------------------------------
// fbcp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fbcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/fbcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbcp_ctrl
// Controller for the framebuffer circle plotter: sequences the clearing
// sweep, pixel read-modify-writes, circle steps, byte reads and the output
// handshake.
// ----------------------------------------------------------------------------
module fbcp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  fbcp_pkg::sts_t sts,
  output fbcp_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_PT_RD,
    S_PT_WR,
    S_STEP,
    S_RD,
    S_RD_DATA,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   clr_item_r, clr_item_nxt;   // sweep was started by a transaction
  logic   accept;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  // Commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    clr_item_nxt  = clr_item_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = clr_item_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (sts.action)
            fbcp_pkg::ACT_SET, fbcp_pkg::ACT_CLR, fbcp_pkg::ACT_CIRCLE: begin
              state_nxt = S_PT_RD;
            end
            fbcp_pkg::ACT_WIPE: begin
              clr_item_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            fbcp_pkg::ACT_READ: begin
              state_nxt = S_RD;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_PT_RD: begin
        cmd.pt_rd = 1'b1;
        state_nxt = S_PT_WR;
      end
      S_PT_WR: begin
        cmd.pt_wr = 1'b1;
        if (!sts.last_pt) begin
          cmd.pt_next = 1'b1;
          state_nxt   = S_PT_RD;
        end else if (sts.a_lt_b) begin
          state_nxt = S_STEP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_PT_RD;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
      clr_item_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_item_r  <= (state_nxt == S_CLR) ? clr_item_nxt : 1'b0;
    end
  end

endmodule

// ===== design/fbcp_datapath.sv =====
// ----------------------------------------------------------------------------
// fbcp_datapath
// Datapath for the framebuffer circle plotter: midpoint error term, point
// address generation, read-modify-write of the frame store, clearing sweep
// and result register.
// ----------------------------------------------------------------------------
module fbcp_datapath #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int DISPLAY_PAGES = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fbcp_pkg::cmd_t             cmd,
  output fbcp_pkg::sts_t             sts,
  input  logic [fbcp_pkg::IN_W-1:0]  in_tdata,
  output logic [fbcp_pkg::OUT_W-1:0] out_tdata
);

  localparam int DEPTH = DISPLAY_WIDTH * DISPLAY_PAGES;
  localparam int ROWS  = DISPLAY_PAGES * 8;
  localparam int AW    = $clog2(DEPTH);

  // Input fields
  logic [2:0] f_action;
  logic [6:0] f_pos_x;
  logic [4:0] f_pos_y;
  logic [5:0] f_radius;
  logic [8:0] f_index;

  assign f_action = in_tdata[2:0];
  assign f_pos_x  = in_tdata[9:3];
  assign f_pos_y  = in_tdata[14:10];
  assign f_radius = in_tdata[20:15];
  assign f_index  = in_tdata[29:21];

  // Item registers
  logic [7:0]      cx_r, cy_r;
  logic [5:0]      a_r, b_r;
  fbcp_pkg::err_t  f_r;
  logic            on_r;
  logic            single_r;
  logic [8:0]      idx_r;
  logic [2:0]      pt_r;
  logic [AW-1:0]   clr_cnt_r;
  logic [AW-1:0]   addr_r;
  logic [7:0]      mask_r;
  logic            ok_r;
  logic [7:0]      res_r;
  logic [7:0]      out_data_r;

  // RAM ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  // Point address: offsets picked by point number, wrapped modulo 256
  logic [5:0]    u, v;
  logic [7:0]    dx, dy, px, py;
  logic [2:0]    page;
  logic          pt_ok;
  logic [AW-1:0] pt_addr;
  logic [7:0]    pt_mask;

  always_comb begin
    u       = pt_r[2] ? b_r : a_r;
    v       = pt_r[2] ? a_r : b_r;
    dx      = pt_r[0] ? (8'd0 - {2'b00, u}) : {2'b00, u};
    dy      = pt_r[1] ? (8'd0 - {2'b00, v}) : {2'b00, v};
    px      = cx_r + dx;
    py      = cy_r + dy;
    page    = py[5:3];
    pt_ok   = ({1'b0, px} < 9'(DISPLAY_WIDTH)) && ({1'b0, py} < 9'(ROWS));
    pt_addr = AW'(page) * AW'(DISPLAY_WIDTH) + AW'(px);
    pt_mask = 8'd1 << py[2:0];
  end

  // Midpoint error term step
  fbcp_pkg::err_t a2, b2, f_adj, f_nxt;
  logic           f_ge0;

  always_comb begin
    a2    = fbcp_pkg::err_t'({a_r, 1'b0});
    b2    = fbcp_pkg::err_t'({b_r, 1'b0});
    f_ge0 = (f_r >= 0);
    f_adj = f_ge0 ? (f_r - b2 + fbcp_pkg::err_t'(2)) : f_r;
    f_nxt = f_adj + a2 + fbcp_pkg::err_t'(3);
  end

  // Frame store port steering
  always_comb begin
    ram_re    = cmd.pt_rd || cmd.rd_issue;
    ram_raddr = cmd.pt_rd ? pt_addr : AW'(idx_r);
    ram_we    = (cmd.pt_wr && ok_r) || cmd.clr_wr;
    ram_waddr = cmd.clr_wr ? clr_cnt_r : addr_r;
    if (cmd.clr_wr) begin
      ram_wdata = 8'h00;
    end else if (on_r) begin
      ram_wdata = ram_rdata | mask_r;
    end else begin
      ram_wdata = ram_rdata & ~mask_r;
    end
  end

  fbcp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status back to the controller
  assign sts.action   = f_action;
  assign sts.last_pt  = single_r || (pt_r == 3'd7);
  assign sts.a_lt_b   = (a_r < b_r);
  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));

  // Sweep counter, back at zero after every sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + 1'b1;
    end
  end

  // Item and circle registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r     <= {1'b0, f_pos_x};
      cy_r     <= {3'b000, f_pos_y};
      a_r      <= '0;
      b_r      <= (f_action == fbcp_pkg::ACT_CIRCLE) ? f_radius : 6'd0;
      f_r      <= fbcp_pkg::err_t'(1) - fbcp_pkg::err_t'(f_radius);
      on_r     <= (f_action != fbcp_pkg::ACT_CLR);
      single_r <= (f_action != fbcp_pkg::ACT_CIRCLE);
      idx_r    <= f_index;
      pt_r     <= '0;
    end else if (cmd.step) begin
      f_r  <= f_nxt;
      a_r  <= a_r + 6'd1;
      b_r  <= f_ge0 ? b_r - 6'd1 : b_r;
      pt_r <= '0;
    end else if (cmd.pt_next) begin
      pt_r <= pt_r + 3'd1;
    end
  end

  // Point address and mask held across the read-modify-write
  always_ff @(posedge clk) begin
    if (cmd.pt_rd) begin
      addr_r <= pt_addr;
      mask_r <= pt_mask;
      ok_r   <= pt_ok;
    end
  end

  // Result and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= 8'h00;
    end else if (cmd.rd_cap) begin
      res_r <= (32'(idx_r) < DEPTH) ? ram_rdata : 8'h00;
    end
    if (cmd.fin_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_tdata = out_data_r;

endmodule
